>>> src/cdie_pkg.sv
// cdie_pkg: shared types and constants of the common packet format item extractor
// used by every module of the block and by its checker
`timescale 1ns / 1ps
`default_nettype none

package cdie_pkg;

	localparam int unsigned LENGTH_BITS  = 16;
	localparam int unsigned FIXED_HEADER = 8;
	localparam int unsigned ITEM_HEADER  = 4;

	localparam logic [15:0] LEN_MASK = (LENGTH_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << LENGTH_BITS) - 32'd1);

	localparam logic [15:0] TARGET_RESET = 16'h00B2;

	// register index on the config port
	localparam logic REG_TARGET_TYPE = 1'b0;

	localparam int unsigned PADDR_W = 3;

	typedef enum logic [1:0] {
		OC_PENDING   = 2'd0,
		OC_FOUND     = 2'd1,
		OC_NOT_FOUND = 2'd2,
		OC_BAD       = 2'd3
	} outcome_t;

	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        out_last;
		logic [15:0] item_length;
		logic        done_res;
		outcome_t    outcome;
	} res_t;

endpackage

`default_nettype wire

>>> src/cdie_cfg.sv
// cdie_cfg: apb register file holding the target item type
// depends on cdie_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdie_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cdie_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	output logic      [15:0]                  target_type
);
	import cdie_pkg::*;

	logic [15:0] target_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_TARGET_TYPE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (wr_en) begin
			target_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_TARGET_TYPE) begin
			prdata = {16'h0000, target_q};
		end
	end

	assign target_type = target_q;

endmodule

`default_nettype wire

>>> src/cdie_parser.sv
// cdie_parser: parse state registers and the per-byte next-state and result logic
// depends on cdie_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdie_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_take,
	input  wire logic          start_req,
	input  wire logic [7:0]    data_byte,
	input  wire logic [15:0]   payload_length,
	input  wire logic [15:0]   target_type,
	output cdie_pkg::res_t     res
);
	import cdie_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE, PH_HEADER, PH_ITEM_HDR, PH_SKIP, PH_DATA, PH_DONE
	} phase_t;

	phase_t      phase_q;
	logic [16:0] offset_q;
	logic [15:0] frame_q;
	logic [15:0] items_q;
	logic [31:0] shift_q;
	logic [15:0] dleft_q;
	logic [15:0] sel_q;
	logic [2:0]  hcnt_q;
	outcome_t    oc_q;

	phase_t      ph;
	logic [16:0] off;
	logic [15:0] frm;
	logic [15:0] items;
	logic [31:0] shift;
	logic [15:0] dleft;
	logic [15:0] sel;
	logic [2:0]  hcnt;
	outcome_t    oc;
	logic        nxt;
	logic [15:0] ilen;
	logic        done;

	always_comb begin
		ph    = phase_q;
		off   = offset_q;
		frm   = frame_q;
		items = items_q;
		shift = shift_q;
		dleft = dleft_q;
		sel   = sel_q;
		hcnt  = hcnt_q;
		oc    = oc_q;
		nxt   = 1'b0;
		done  = 1'b0;
		ilen  = shift_q[31:16];
		res   = '0;

		if (start_req) begin
			frm   = payload_length & LEN_MASK;
			off   = '0;
			items = '0;
			shift = '0;
			dleft = '0;
			sel   = '0;
			hcnt  = '0;
			oc    = OC_PENDING;
			if (frm < 16'(FIXED_HEADER)) begin
				oc   = OC_BAD;
				ph   = PH_DONE;
				done = 1'b1;
			end else begin
				ph = PH_HEADER;
			end
		end

		case (ph)
			PH_HEADER: begin
				shift = {data_byte, shift[31:8]};
				off   = off + 17'd1;
				if (off == 17'(FIXED_HEADER)) begin
					items = shift[31:16];
					nxt   = 1'b1;
				end
			end
			PH_ITEM_HDR: begin
				shift = {data_byte, shift[31:8]};
				off   = off + 17'd1;
				hcnt  = hcnt + 3'd1;
				ilen  = shift[31:16];
				if (hcnt >= 3'(ITEM_HEADER)) begin
					if (({1'b0, off} + {2'b00, ilen}) > {2'b00, frm}) begin
						oc   = OC_BAD;
						ph   = PH_DONE;
						done = 1'b1;
					end else if (shift[15:0] == target_type) begin
						sel  = ilen;
						oc   = OC_FOUND;
						ph   = PH_DONE;
						done = 1'b1;
						if (ilen != 16'd0) begin
							ph    = PH_DATA;
							dleft = ilen;
						end
					end else begin
						items = items - 16'd1;
						if (ilen == 16'd0) begin
							nxt = 1'b1;
						end else begin
							ph    = PH_SKIP;
							dleft = ilen;
						end
					end
				end
			end
			PH_SKIP: begin
				off   = off + 17'd1;
				dleft = dleft - 16'd1;
				if (dleft == 16'd0) begin
					nxt = 1'b1;
				end
			end
			PH_DATA: begin
				off           = off + 17'd1;
				dleft         = dleft - 16'd1;
				res.out_valid = 1'b1;
				res.out_byte  = data_byte;
				if (dleft == 16'd0) begin
					res.out_last = 1'b1;
					ph           = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		// end of header or of a skipped item
		if (nxt) begin
			if (items == 16'd0) begin
				oc   = OC_NOT_FOUND;
				ph   = PH_DONE;
				done = 1'b1;
			end else if (({1'b0, off} + 18'(ITEM_HEADER)) > {2'b00, frm}) begin
				oc   = OC_BAD;
				ph   = PH_DONE;
				done = 1'b1;
			end else begin
				ph   = PH_ITEM_HDR;
				hcnt = '0;
			end
		end

		res.done_res    = done;
		res.outcome     = oc;
		res.item_length = (oc == OC_FOUND) ? sel : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			offset_q <= '0;
			frame_q  <= '0;
			items_q  <= '0;
			shift_q  <= '0;
			dleft_q  <= '0;
			sel_q    <= '0;
			hcnt_q   <= '0;
			oc_q     <= OC_PENDING;
		end else if (in_take) begin
			phase_q  <= ph;
			offset_q <= off;
			frame_q  <= frm;
			items_q  <= items;
			shift_q  <= shift;
			dleft_q  <= dleft;
			sel_q    <= sel;
			hcnt_q   <= hcnt;
			oc_q     <= oc;
		end
	end

endmodule

`default_nettype wire

>>> src/cdie_outreg.sv
// cdie_outreg: result register between the parser and the master stream side
// depends on cdie_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdie_outreg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  cdie_pkg::res_t      res_in,
	output logic                space,
	output logic                valid,
	input  wire logic           ready,
	output cdie_pkg::res_t      res_out
);
	import cdie_pkg::*;

	logic valid_q;
	res_t res_q;

	assign space   = !valid_q || ready;
	assign valid   = valid_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire

>>> src/cpf_data_item_extractor.sv
// cpf_data_item_extractor: top level, extracts the data of one item from a
// request-reply payload streamed a byte per transfer; uses cdie_pkg, cdie_cfg,
// cdie_parser and cdie_outreg
//
// channel   dir  carries
// s_*       in   payload byte, payload length, start flag
// m_*       out  one result per input byte (data byte, item length, outcome, flags)
// apb       in   target item type register at byte address 0
//
// a byte can be taken every cycle while the result register has space; the parse
// state and one result register set that rate
// a result appears on m_* the cycle after its byte is taken
// while m_tready is low the result is held and s_tready drops only if the
// result register is still full
// arst_n clears the parse state, the result valid and the target type to 0x00B2
`timescale 1ns / 1ps
`default_nettype none

module cpf_data_item_extractor (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [23:0]                  s_tdata,  // data_byte[7:0], payload_length[23:8]
	input  wire logic [0:0]                   s_tuser,  // start_req[0]
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [31:0]                  m_tdata,  // out_byte[7:0], item_length[23:8],
	                                                    // outcome[25:24], zero[31:26]
	output logic      [1:0]                   m_tuser,  // out_valid[0], done_res[1]
	output logic                              m_tlast,  // out_last
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cdie_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);
	import cdie_pkg::*;

	logic [15:0] target_type;
	logic        space;
	logic        in_take;
	res_t        res_new;
	res_t        res_cur;

	assign s_tready = space;
	assign in_take  = s_tvalid && space;

	cdie_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.target_type (target_type)
	);

	cdie_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_take        (in_take),
		.start_req      (s_tuser[0]),
		.data_byte      (s_tdata[7:0]),
		.payload_length (s_tdata[23:8]),
		.target_type    (target_type),
		.res            (res_new)
	);

	cdie_outreg u_outreg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (in_take),
		.res_in  (res_new),
		.space   (space),
		.valid   (m_tvalid),
		.ready   (m_tready),
		.res_out (res_cur)
	);

	assign m_tdata = {6'b000000, res_cur.outcome, res_cur.item_length, res_cur.out_byte};
	assign m_tuser = {res_cur.done_res, res_cur.out_valid};
	assign m_tlast = res_cur.out_last;

endmodule

`default_nettype wire

>>> src/cdie_checker.sv
// cdie_checker: port-level assertions for the item extractor, bound to the top level
// depends on cdie_pkg and cpf_data_item_extractor
`timescale 1ns / 1ps
`default_nettype none

module cdie_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);
	import cdie_pkg::*;

	// a stalled transfer stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// data bytes only come out of a found item
	a_data_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[25:24] == OC_FOUND)
		else $error("data byte without found outcome");

	// last marks a data byte
	a_last_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("last without data byte");

	// done carries a final outcome
	a_done_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[25:24] != OC_PENDING)
		else $error("done with pending outcome");

	// item length is zero unless an item was found
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[25:24] != OC_FOUND |-> m_tdata[23:8] == 16'd0)
		else $error("item length without found outcome");

endmodule

bind cpf_data_item_extractor cdie_checker u_cdie_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
